@@ design/bitmap_block_allocator_top_assert.svh @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top_assert.svh
// Assertion macros for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bba: implication check failed");

// Next-cycle implication, checked out of reset.
`define BBA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bba: next-cycle check failed");

`endif

@@ design/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Types, sizes and codes of the free-block bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    // Map geometry
    localparam int NUM_BLOCKS      = 16384;
    localparam int MAP_BLOCK_BYTES = 512;
    localparam int WORD_BITS       = 64;
    localparam int NUM_WORDS       = NUM_BLOCKS / WORD_BITS;
    localparam int GROUP_WORDS     = 16;
    localparam int NUM_GROUPS      = NUM_WORDS / GROUP_WORDS;

    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int WADDR_W   = $clog2(NUM_WORDS);
    localparam int GRP_IDX_W = $clog2(GROUP_WORDS);
    localparam int GROUP_W   = $clog2(NUM_GROUPS);
    localparam int NW_W      = WADDR_W + 1;
    localparam int MAP_SHIFT = $clog2(8 * MAP_BLOCK_BYTES);

    // Field widths
    localparam int ID_W  = 14;
    localparam int LIM_W = 15;
    localparam int MB_W  = 2;
    localparam int ST_W  = 2;

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE_FREE = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd16384;

    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] block_id;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] granted_block;
        logic [MB_W-1:0] map_block;
        logic [ST_W-1:0] status;
    } t_out_item;

    // Summary update from the control FSM
    typedef struct packed {
        logic               en;
        logic [WADDR_W-1:0] word;
        logic               has_free;
    } t_sum_upd;

    // Summary lookup results back to the control FSM
    typedef struct packed {
        logic               grp_hit;
        logic [WADDR_W-1:0] hit_word;
        logic               word_valid;
    } t_sum_stat;

endpackage

`default_nettype wire

@@ design/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/bba_summary.sv @@
// ----------------------------------------------------------------------------
// bba_summary
// Per-word free summary and written flags, with a one-group search step.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_summary (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [bba_pkg::GROUP_W-1:0] i_grp,
    input  wire logic [bba_pkg::NW_W-1:0]    i_num_words,
    input  wire logic [bba_pkg::WADDR_W-1:0] i_vld_word,
    input  wire bba_pkg::t_sum_upd          i_upd,
    output      bba_pkg::t_sum_stat         o_stat
);
    import bba_pkg::*;

    logic [NUM_WORDS-1:0]   r_sum;
    logic [NUM_WORDS-1:0]   r_vld;
    logic [GROUP_WORDS-1:0] grp_bits;
    logic [GROUP_WORDS-1:0] elig;
    logic [GROUP_WORDS-1:0] cand;
    logic [GROUP_WORDS-1:0] low;
    logic [GRP_IDX_W-1:0]   idx;

    // Summary bits: set means the word still holds a free block.
    // A word never written reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '1;
            r_vld <= '0;
        end else if (i_upd.en) begin
            r_sum[i_upd.word] <= i_upd.has_free;
            r_vld[i_upd.word] <= 1'b1;
        end
    end

    // Lowest eligible word with free blocks inside the current group
    always_comb begin
        logic [WADDR_W-1:0] wk;
        wk       = '0;
        grp_bits = r_sum[i_grp*GROUP_WORDS +: GROUP_WORDS];
        for (int k = 0; k < GROUP_WORDS; k++) begin
            wk      = {i_grp, GRP_IDX_W'(k)};
            elig[k] = ({1'b0, wk} < i_num_words);
        end
        cand = grp_bits & elig;
        low  = cand & (~cand + GROUP_WORDS'(1));
        idx  = '0;
        for (int k = 0; k < GROUP_WORDS; k++) begin
            if (low[k]) begin
                idx = idx | GRP_IDX_W'(k);
            end
        end
    end

    assign o_stat.grp_hit    = |cand;
    assign o_stat.hit_word   = {i_grp, idx};
    assign o_stat.word_valid = r_vld[i_vld_word];

endmodule

`default_nettype wire

@@ design/bba_bit_find.sv @@
// ----------------------------------------------------------------------------
// bba_bit_find
// Lowest set bit of one bitmap word.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_bit_find (
    input  wire logic [bba_pkg::WORD_BITS-1:0] i_bits,
    output      logic                         o_found,
    output      logic [bba_pkg::BIT_W-1:0]     o_index
);
    import bba_pkg::*;

    logic [WORD_BITS-1:0] low;

    // Isolate the lowest set bit, then encode the one-hot result
    always_comb begin
        low     = i_bits & (~i_bits + WORD_BITS'(1));
        o_index = '0;
        for (int k = 0; k < WORD_BITS; k++) begin
            if (low[k]) begin
                o_index = o_index | BIT_W'(k);
            end
        end
    end

    assign o_found = |i_bits;

endmodule

`default_nettype wire

@@ design/bitmap_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit free-block bitmap allocator with a word summary.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_in_item) takes one request:
//   allocate the lowest free block below the limit, or release block_id.
//   Output channel (o_out_valid / i_out_stall, o_out_item) returns exactly
//   one result per request: block number, bitmap disk block, status.
//   Config channel (i_cfg_valid / o_cfg_ready) writes blocks_in_use; it is
//   always ready. The user must write it only while the block is idle; the
//   block itself does not enforce this. One request is in work at a time:
//   an in-range release reads the bitmap word, sets the bit and writes it
//   back; an out-of-range release goes straight to its result; an allocate
//   scans the summary groups in order (1 to 16), then reads the hit word,
//   clears its lowest free bit and writes it back, or, when no group has a
//   free word, goes to its result after the last group. The input reopens
//   as the result enters the output register, and not before.
//   A result stalled downstream holds the following request in its final
//   state until the output register frees up.
//   Reset marks every block free at once (words never written read as all
//   free) and sets the limit to 16384; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_top (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output      logic                     o_in_stall,
    input  wire bba_pkg::t_in_item        i_in_item,
    output      logic                     o_out_valid,
    input  wire logic                     i_out_stall,
    output      bba_pkg::t_out_item       o_out_item,
    input  wire logic                     i_cfg_valid,
    output      logic                     o_cfg_ready,
    input  wire logic [bba_pkg::LIM_W-1:0] i_cfg_data
);
    import bba_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_READ = 5'b00100,
        S_MOD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state               r_state,  n_state;
    t_in_item             r_req,    n_req;
    logic [GROUP_W-1:0]   r_grp,    n_grp;
    logic [WADDR_W-1:0]   r_word,   n_word;
    t_out_item            r_res,    n_res;
    t_out_item            r_out,    n_out;
    logic                 r_out_valid, n_out_valid;
    logic [LIM_W-1:0]     r_blocks;

    logic [LIM_W-1:0]     lim;
    logic [LIM_W:0]       lim_up;
    logic [NW_W-1:0]      num_words;
    logic [NW_W-1:0]      nw_m1;
    logic [GROUP_W-1:0]   last_grp;
    logic [NW_W-1:0]      lim_word;
    logic [BIT_W-1:0]     lim_bit;

    logic                 in_xfer;
    logic                 out_free;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] masked;
    logic                 bit_found;
    logic [BIT_W-1:0]     bit_idx;
    logic [ID_W-1:0]      grant_id;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;
    t_sum_upd             sum_upd;
    t_sum_stat            sum_stat;

    // Config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_blocks <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    // Active limit and the derived scan bounds
    always_comb begin
        lim       = (r_blocks > LIM_W'(NUM_BLOCKS)) ? LIM_W'(NUM_BLOCKS) : r_blocks;
        lim_up    = {1'b0, lim} + (LIM_W+1)'(WORD_BITS - 1);
        num_words = NW_W'(lim_up >> BIT_W);
        nw_m1     = num_words - NW_W'(1);
        last_grp  = (num_words == '0) ? '0 : GROUP_W'(nw_m1 >> GRP_IDX_W);
        lim_word  = NW_W'(lim >> BIT_W);
        lim_bit   = lim[BIT_W-1:0];
    end

    // Word summary and group search
    bba_summary u_summary (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (r_grp),
        .i_num_words (num_words),
        .i_vld_word  (r_word),
        .i_upd       (sum_upd),
        .o_stat      (sum_stat)
    );

    // Bitmap words
    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_word),
        .i_wr_data (wr_data),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_word),
        .o_rd_data (rd_data)
    );

    // Word under modification, masked to the blocks below the limit
    always_comb begin
        cur_word = sum_stat.word_valid ? rd_data : '1;
        if ({1'b0, r_word} < lim_word) begin
            word_mask = '1;
        end else begin
            word_mask = (WORD_BITS'(1) << lim_bit) - WORD_BITS'(1);
        end
        masked = cur_word & word_mask;
    end

    bba_bit_find u_bit_find (
        .i_bits  (masked),
        .o_found (bit_found),
        .o_index (bit_idx)
    );

    assign grant_id = {r_word, bit_idx};
    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Control FSM
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_grp       = r_grp;
        n_word      = r_word;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_data     = cur_word;
        sum_upd     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_req = i_in_item;
                    n_grp = '0;
                    if (i_in_item.req_type == REQ_ALLOC) begin
                        n_state = S_SCAN;
                    end else if ({1'b0, i_in_item.block_id} >= lim) begin
                        n_res.granted_block = i_in_item.block_id;
                        n_res.map_block     = '0;
                        n_res.status        = ST_RANGE;
                        n_state             = S_DONE;
                    end else begin
                        n_word  = i_in_item.block_id[ID_W-1:BIT_W];
                        n_state = S_READ;
                    end
                end
            end
            S_SCAN: begin
                if (sum_stat.grp_hit) begin
                    n_word  = sum_stat.hit_word;
                    n_state = S_READ;
                end else if (r_grp == last_grp) begin
                    n_res.granted_block = '0;
                    n_res.map_block     = '0;
                    n_res.status        = ST_NONE_FREE;
                    n_state             = S_DONE;
                end else begin
                    n_grp = r_grp + GROUP_W'(1);
                end
            end
            S_READ: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                n_state = S_DONE;
                if (r_req.req_type == REQ_FREE) begin
                    wr_en            = 1'b1;
                    wr_data          = cur_word
                                     | (WORD_BITS'(1) << r_req.block_id[BIT_W-1:0]);
                    sum_upd.en       = 1'b1;
                    sum_upd.word     = r_word;
                    sum_upd.has_free = 1'b1;
                    n_res.granted_block = r_req.block_id;
                    n_res.map_block     = MB_W'(r_req.block_id >> MAP_SHIFT);
                    n_res.status        = ST_OK;
                end else if (bit_found) begin
                    wr_en            = 1'b1;
                    wr_data          = cur_word & ~(WORD_BITS'(1) << bit_idx);
                    sum_upd.en       = 1'b1;
                    sum_upd.word     = r_word;
                    sum_upd.has_free = |wr_data;
                    n_res.granted_block = grant_id;
                    n_res.map_block     = MB_W'(grant_id >> MAP_SHIFT);
                    n_res.status        = ST_OK;
                end else begin
                    // Only the partial word at the limit can land here
                    n_res.granted_block = '0;
                    n_res.map_block     = '0;
                    n_res.status        = ST_NONE_FREE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_grp  <= n_grp;
        r_word <= n_word;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Checks
`include "bitmap_block_allocator_top_assert.svh"

    `BBA_ASSERT_IMP(a_grant_below_limit,
        (r_state == S_MOD && r_req.req_type == REQ_ALLOC && bit_found),
        ({1'b0, grant_id} < lim))
    `BBA_ASSERT_IMP(a_summary_tracks_word, sum_upd.en, (sum_upd.has_free == (|wr_data)))
    `BBA_ASSERT_NXT(a_done_waits_for_slot,
        (r_state == S_DONE && r_out_valid && i_out_stall), (r_state == S_DONE))
    `BBA_ASSERT_NXT(a_busy_after_transfer, in_xfer, (r_state != S_IDLE))

endmodule

`default_nettype wire
